// File: hdl/wllv_pkg.sv
// wllv_pkg: shared constants, codes and types of the wear-leveled last-value log
// no dependencies; used by wllv_ctrl and wear_leveled_last_value_log
package wllv_pkg;

  localparam int LOG_WORDS_DEF  = 8192;
  localparam int PAGE_WORDS_DEF = 512;

  localparam int DATA_W    = 16;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0] ERASED_WORD  = 16'hFFFF;
  localparam logic [DATA_W-1:0] MISS_VALUE   = 16'd1;

  // item modes
  localparam logic [MODE_W-1:0] MODE_STORE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RECALL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ERASE  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_SETTING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_INVERT  = 2'd1;

  // recall result handed from the sequencer to the output register
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] recalled;
    logic              found;
  } res_t;

endpackage

// File: hdl/wear_leveled_last_value_log.sv
// wear_leveled_last_value_log: top level with config registers and result register
// depends on wllv_pkg, wllv_ram and wllv_ctrl
// a store that opens a page first runs a page erase sweep, then writes the record
// recall: scans up from word 0 to the newest record, or to the top word on a miss;
// when recall is off it returns a miss without a scan; erase-all: one write per cycle
// one item at a time, bounded by the single write/read port pair of the log memory
// reset: synchronous active-low; a clearing sweep erases every word of the log,
// during which no input transaction is accepted (config writes are always taken)
module wear_leveled_last_value_log #(
  parameter int LOG_WORDS  = wllv_pkg::LOG_WORDS_DEF,
  parameter int PAGE_WORDS = wllv_pkg::PAGE_WORDS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wllv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic                               cfg_wdata,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [wllv_pkg::DATA_W-1:0]        in_tdata,   // [15:0] value
  input  logic [wllv_pkg::MODE_W-1:0]        in_tuser,   // [1:0] mode
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [wllv_pkg::DATA_W-1:0]        out_tdata,  // [15:0] recalled
  output logic                               out_tuser   // [0] found
);

  localparam int PTR_W = $clog2(LOG_WORDS);

  logic                        enable_setting_r;
  logic                        enable_invert_r;
  logic                        recall_en;

  logic                        out_valid_r, out_valid_nxt;
  logic [wllv_pkg::DATA_W-1:0] out_data_r, out_data_nxt;
  logic                        out_found_r, out_found_nxt;
  logic                        res_ready;

  wllv_pkg::res_t              res;

  logic                        mem_we;
  logic [PTR_W-1:0]            mem_waddr;
  logic [wllv_pkg::DATA_W-1:0] mem_wdata;
  logic [PTR_W-1:0]            mem_raddr;
  logic [wllv_pkg::DATA_W-1:0] mem_rdata;

  // config writes are taken in any cycle; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_setting_r <= 1'b0;
      enable_invert_r  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        wllv_pkg::CFG_ENABLE_SETTING: enable_setting_r <= cfg_wdata;
        wllv_pkg::CFG_ENABLE_INVERT:  enable_invert_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // the invert register flips the user setting
  assign recall_en = enable_setting_r ^ enable_invert_r;

  // log memory: one word per record, erased words read all ones
  wllv_ram #(
    .WIDTH (wllv_pkg::DATA_W),
    .DEPTH (LOG_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer owns the write pointer and every memory access; accesses never
  // overlap since one item runs at a time, so no forwarding is needed
  wllv_ctrl #(
    .LOG_WORDS  (LOG_WORDS),
    .PAGE_WORDS (PAGE_WORDS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (recall_en),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser),
    .in_value  (in_tdata),
    .res       (res),
    .res_ready (res_ready),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // output register: a waiting result does not hold up the next item,
  // only a second result that finds the register still full
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_found_nxt = out_found_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res.valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res.recalled;
      out_found_nxt = res.found;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_found_r;

endmodule

// File: hdl/wllv_ram.sv
// wllv_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
module wllv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/wllv_ctrl.sv
// wllv_ctrl: sequencer that sweeps, erases, writes and scans the log memory
// depends on wllv_pkg; drives the write and read ports of one wllv_ram
module wllv_ctrl #(
  parameter int LOG_WORDS  = wllv_pkg::LOG_WORDS_DEF,
  parameter int PAGE_WORDS = wllv_pkg::PAGE_WORDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [wllv_pkg::MODE_W-1:0]       in_mode,
  input  logic [wllv_pkg::DATA_W-1:0]       in_value,
  output wllv_pkg::res_t                    res,
  input  logic                              res_ready,
  output logic                              mem_we,
  output logic [$clog2(LOG_WORDS)-1:0]      mem_waddr,
  output logic [wllv_pkg::DATA_W-1:0]       mem_wdata,
  output logic [$clog2(LOG_WORDS)-1:0]      mem_raddr,
  input  logic [wllv_pkg::DATA_W-1:0]       mem_rdata
);

  localparam int PTR_W   = $clog2(LOG_WORDS);
  localparam int OFF_W   = $clog2(PAGE_WORDS);
  localparam int TOP_OFF = (LOG_WORDS - 1) % PAGE_WORDS;

  localparam logic [PTR_W-1:0] TOP_PTR  = PTR_W'(LOG_WORDS - 1);
  localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(PAGE_WORDS - 1);
  localparam logic [OFF_W-1:0] TOP_OFFV = OFF_W'(TOP_OFF);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PAGE,
    S_WRITE,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t                      state_r, state_nxt;
  logic [PTR_W-1:0]            ptr_r, ptr_nxt;
  logic [OFF_W-1:0]            off_r, off_nxt;
  logic [PTR_W-1:0]            addr_r, addr_nxt;
  logic [OFF_W-1:0]            soff_r, soff_nxt;
  logic [OFF_W-1:0]            cnt_r, cnt_nxt;
  logic [wllv_pkg::DATA_W-1:0] val_r, val_nxt;
  logic                        rv_r, rv_nxt;
  logic [PTR_W-1:0]            qaddr_r, qaddr_nxt;
  logic [OFF_W-1:0]            qoff_r, qoff_nxt;
  logic [wllv_pkg::DATA_W-1:0] rec_r, rec_nxt;
  logic                        fnd_r, fnd_nxt;
  logic [PTR_W-1:0]            dec_ptr;
  logic [OFF_W-1:0]            dec_off;

  // pointer one word down, wrapping to the top word; page offset follows
  always_comb begin
    if (ptr_r == '0) begin
      dec_ptr = TOP_PTR;
      dec_off = TOP_OFFV;
    end else begin
      dec_ptr = ptr_r - 1'b1;
      dec_off = (off_r == '0) ? LAST_OFF : off_r - 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    off_nxt   = off_r;
    addr_nxt  = addr_r;
    soff_nxt  = soff_r;
    cnt_nxt   = cnt_r;
    val_nxt   = val_r;
    rv_nxt    = rv_r;
    qaddr_nxt = qaddr_r;
    qoff_nxt  = qoff_r;
    rec_nxt   = rec_r;
    fnd_nxt   = fnd_r;
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = wllv_pkg::ERASED_WORD;
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (addr_r == TOP_PTR) begin
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_mode)
            wllv_pkg::MODE_STORE: begin
              if (en) begin
                val_nxt = in_value;
                if (off_r == '0) begin
                  addr_nxt  = ptr_r;
                  cnt_nxt   = '0;
                  state_nxt = S_PAGE;
                end else begin
                  state_nxt = S_WRITE;
                end
              end
            end
            wllv_pkg::MODE_RECALL: begin
              if (en) begin
                addr_nxt  = '0;
                soff_nxt  = '0;
                rv_nxt    = 1'b0;
                state_nxt = S_SCAN;
              end else begin
                ptr_nxt   = TOP_PTR;
                off_nxt   = TOP_OFFV;
                rec_nxt   = wllv_pkg::MISS_VALUE;
                fnd_nxt   = 1'b0;
                state_nxt = S_RESULT;
              end
            end
            wllv_pkg::MODE_ERASE: begin
              addr_nxt  = '0;
              state_nxt = S_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      S_PAGE: begin
        mem_we = 1'b1;
        if (cnt_r == LAST_OFF || addr_r == TOP_PTR) begin
          state_nxt = S_WRITE;
        end else begin
          addr_nxt = addr_r + 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = dec_ptr;
        mem_wdata = val_r;
        ptr_nxt   = dec_ptr;
        off_nxt   = dec_off;
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (rv_r && mem_rdata != wllv_pkg::ERASED_WORD) begin
          ptr_nxt   = qaddr_r;
          off_nxt   = qoff_r;
          rec_nxt   = mem_rdata;
          fnd_nxt   = 1'b1;
          state_nxt = S_RESULT;
        end else if (rv_r && qaddr_r == TOP_PTR) begin
          ptr_nxt   = TOP_PTR;
          off_nxt   = TOP_OFFV;
          rec_nxt   = wllv_pkg::MISS_VALUE;
          fnd_nxt   = 1'b0;
          state_nxt = S_RESULT;
        end else begin
          rv_nxt    = 1'b1;
          qaddr_nxt = addr_r;
          qoff_nxt  = soff_r;
          addr_nxt  = addr_r + 1'b1;
          soff_nxt  = (soff_r == LAST_OFF) ? '0 : soff_r + 1'b1;
        end
      end
      S_RESULT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ptr_r   <= '0;
      off_r   <= '0;
      addr_r  <= '0;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      off_r   <= off_nxt;
      addr_r  <= addr_nxt;
      rv_r    <= rv_nxt;
    end
    soff_r  <= soff_nxt;
    cnt_r   <= cnt_nxt;
    val_r   <= val_nxt;
    qaddr_r <= qaddr_nxt;
    qoff_r  <= qoff_nxt;
    rec_r   <= rec_nxt;
    fnd_r   <= fnd_nxt;
  end

  assign in_ready     = (state_r == S_IDLE);
  assign mem_raddr    = addr_r;
  assign res.valid    = (state_r == S_RESULT);
  assign res.recalled = rec_r;
  assign res.found    = fnd_r;

  // the scan only reads
  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !mem_we)
    else $error("memory written during scan");

  // a miss leaves the pointer on the top word
  a_miss_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && !res.found) |-> (ptr_r == TOP_PTR && rec_r == wllv_pkg::MISS_VALUE))
    else $error("miss result without pointer at top");

  // a hit never returns an erased word
  a_hit_data: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.found) |-> (res.recalled != wllv_pkg::ERASED_WORD))
    else $error("hit result carries erased word");

  // pointer stays inside the store
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= TOP_PTR)
    else $error("write pointer outside the store");

endmodule
